/* sv/stlp_pkg.sv */
// stlp_pkg: shared types and constants for the stall-to-load lookup.
// Used by the channel interfaces and the stall_to_load_percent top level.
`timescale 1ns / 1ps
`default_nettype none

package stlp_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int VAL_W   = 16;   // speed and stall readings
    localparam int CNT_W   = 5;    // entries_in_use register
    localparam int SLOT_W  = 4;    // entry_index and nearest_entry
    localparam int PCT_W   = 7;    // load_percent
    localparam int QUO_MSB = 6;    // top quotient bit, result is at most 100
    localparam int DIVD_W  = 23;   // 16-bit magnitude times 100

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] speed;
        logic [VAL_W-1:0] noload;
        logic [VAL_W-1:0] fullload;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_BS_RD,
        ST_BS_CMP,
        ST_NR_LO,
        ST_NR_HI,
        ST_FETCH,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/stlp_in_if.sv */
// stlp_in_if: valid/ready channel carrying command beats into the block.
// Field widths come from stlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stlp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [stlp_pkg::SLOT_W-1:0] entry_index;
    logic [stlp_pkg::VAL_W-1:0]  entry_speed;
    logic [stlp_pkg::VAL_W-1:0]  entry_noload_stall;
    logic [stlp_pkg::VAL_W-1:0]  entry_fullload_stall;
    logic [stlp_pkg::VAL_W-1:0]  query_speed;
    logic [stlp_pkg::VAL_W-1:0]  query_stall;

    modport source (
        output valid, command, entry_index, entry_speed, entry_noload_stall,
               entry_fullload_stall, query_speed, query_stall,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_speed, entry_noload_stall,
               entry_fullload_stall, query_speed, query_stall,
        output ready
    );
endinterface

`default_nettype wire

/* sv/stlp_out_if.sv */
// stlp_out_if: valid/ready channel carrying result beats out of the block.
// Field widths come from stlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stlp_out_if;
    logic                        valid;
    logic                        ready;
    logic [stlp_pkg::PCT_W-1:0]  load_percent;
    logic [stlp_pkg::SLOT_W-1:0] nearest_entry;
    logic                        calibration_error;

    modport source (
        output valid, load_percent, nearest_entry, calibration_error,
        input  ready
    );
    modport sink (
        input  valid, load_percent, nearest_entry, calibration_error,
        output ready
    );
endinterface

`default_nettype wire

/* sv/stall_to_load_percent.sv */
// stall_to_load_percent: calibration table lookup and load percentage.
// Depends on stlp_pkg, stlp_in_if and stlp_out_if.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------------
//  i_in      | in  | valid/ready        | command, entry_*, query_speed/stall
//  o_out     | out | valid/ready        | load_percent, nearest_entry, cal. error
//  cfg       | in  | i_cfg_we, no wait  | entries_in_use (i_cfg_wdata)
//
// A write beat writes the table at the accepting edge.
// A query beat walks one table read port under a sequencer: one or two end
// checks, binary-search probes of a read and a compare each (at most
// floor(log2(TABLE_DEPTH))+1 probes) and a step to leave the loop, a
// nearest pick, an entry fetch, a restoring divide (skipped on a flat
// entry) and a hand-over.
// i_in.ready is high only in idle. A finished result waits in the sequencer
// until the output register is free, so a stalled sink stops new queries.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// sets entries_in_use to 1; the table itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stall_to_load_percent #(
    parameter int TABLE_DEPTH = stlp_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    stlp_in_if.sink                          i_in,
    stlp_out_if.source                       o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [stlp_pkg::CNT_W-1:0]  i_cfg_wdata
);

    // IW addresses the table, CW holds counts up to TABLE_DEPTH itself.
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = (IW > stlp_pkg::SLOT_W) ? IW : stlp_pkg::SLOT_W;
    localparam int VW = stlp_pkg::VAL_W;
    localparam int DW = stlp_pkg::DIVD_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    stlp_pkg::t_state r_state, n_state;

    logic [stlp_pkg::CNT_W-1:0] r_eiu;

    stlp_pkg::t_entry r_mem [TABLE_DEPTH];
    stlp_pkg::t_entry r_rd;

    logic [VW-1:0] r_q,   n_q;       // query speed
    logic [VW-1:0] r_st,  n_st;      // query stall
    logic [CW-1:0] r_n,   n_n;       // active entry count
    logic [CW-1:0] r_lo,  n_lo;
    logic [CW-1:0] r_hi,  n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_idx, n_idx;     // chosen entry
    logic [VW-1:0] r_slo, n_slo;     // speed at lo after the search
    logic [DW-1:0] r_rem, n_rem;     // divide remainder
    logic [VW-1:0] r_den, n_den;     // divisor magnitude
    logic [stlp_pkg::PCT_W-1:0] r_quo, n_quo;
    logic [2:0]    r_step, n_step;
    logic          r_cerr, n_cerr;

    logic                          r_out_valid;
    logic [stlp_pkg::PCT_W-1:0]    r_out_pct;
    logic [stlp_pkg::SLOT_W-1:0]   r_out_near;
    logic                          r_out_err;

    logic [IW-1:0] rd_addr;

    // ---------------------------------------------------------------
    // Handshake decode
    // ---------------------------------------------------------------
    logic in_beat, wr_beat, q_beat, out_free, slot_ok;
    logic [WW-1:0] wr_wide;
    logic [IW-1:0] wr_addr;

    assign i_in.ready = (r_state == stlp_pkg::ST_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign wr_beat    = in_beat && (i_in.command == stlp_pkg::CMD_WRITE);
    assign q_beat     = in_beat && (i_in.command == stlp_pkg::CMD_QUERY);
    assign out_free   = !r_out_valid || o_out.ready;

    // Slots beyond the table are dropped.
    assign slot_ok = int'(i_in.entry_index) < TABLE_DEPTH;
    assign wr_wide = WW'(i_in.entry_index);
    assign wr_addr = wr_wide[IW-1:0];

    // Clamp entries_in_use to 1..TABLE_DEPTH at query start.
    logic [CW-1:0] cnt_clamped;
    always_comb begin
        if (r_eiu == '0) begin
            cnt_clamped = CW'(1);
        end else if (int'(r_eiu) > TABLE_DEPTH) begin
            cnt_clamped = CW'(TABLE_DEPTH);
        end else begin
            cnt_clamped = CW'(r_eiu);
        end
    end

    // ---------------------------------------------------------------
    // Shared compare / arithmetic
    // ---------------------------------------------------------------
    logic          q_lt, q_gt;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] n_minus1;
    logic          lo_le_hi;
    logic signed [VW:0] dlo, dhi;

    assign q_lt     = r_q < r_rd.speed;
    assign q_gt     = r_q > r_rd.speed;
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign n_minus1 = r_n - CW'(1);
    assign lo_le_hi = r_lo <= r_hi;
    // Signed distances for the final nearest pick (unsorted tables too).
    assign dlo = $signed({1'b0, r_slo}) - $signed({1'b0, r_q});
    assign dhi = $signed({1'b0, r_q}) - $signed({1'b0, r_rd.speed});

    // Clamp the stall reading and form the magnitudes for the divide.
    // With noload below fullload the ratio is 0 or exactly 1, so the
    // quotient of the magnitudes is always the right answer.
    logic [VW-1:0]      normed;
    logic signed [VW:0] num_s, den_s;
    logic [VW-1:0]      num_mag, den_mag;
    logic [DW-1:0]      dividend;
    logic [DW-1:0]      div_shift;
    logic               div_take;

    always_comb begin
        if (r_rd.noload < r_st) begin
            normed = r_rd.noload;
        end else if (r_rd.fullload > r_st) begin
            normed = r_rd.fullload;
        end else begin
            normed = r_st;
        end
    end

    assign num_s    = $signed({1'b0, r_rd.noload}) - $signed({1'b0, normed});
    assign den_s    = $signed({1'b0, r_rd.noload}) - $signed({1'b0, r_rd.fullload});
    assign num_mag  = num_s[VW] ? VW'(-num_s) : num_s[VW-1:0];
    assign den_mag  = den_s[VW] ? VW'(-den_s) : den_s[VW-1:0];
    assign dividend = DW'(num_mag) * DW'(stlp_pkg::PCT_SCALE);

    // One restoring step per cycle, quotient bit r_step.
    assign div_shift = DW'(r_den) << r_step;
    assign div_take  = r_rem >= div_shift;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            stlp_pkg::ST_IDLE: begin
                if (q_beat) begin
                    n_state = stlp_pkg::ST_CHK_FIRST;
                end
            end
            stlp_pkg::ST_CHK_FIRST: begin
                n_state = q_lt ? stlp_pkg::ST_FETCH : stlp_pkg::ST_CHK_LAST;
            end
            stlp_pkg::ST_CHK_LAST: begin
                n_state = q_gt ? stlp_pkg::ST_FETCH : stlp_pkg::ST_BS_RD;
            end
            stlp_pkg::ST_BS_RD: begin
                if (lo_le_hi) begin
                    n_state = stlp_pkg::ST_BS_CMP;
                end else if (r_lo >= r_n) begin
                    n_state = stlp_pkg::ST_FETCH;
                end else begin
                    n_state = stlp_pkg::ST_NR_LO;
                end
            end
            stlp_pkg::ST_BS_CMP: begin
                if (q_lt) begin
                    n_state = (r_mid == '0) ? stlp_pkg::ST_FETCH : stlp_pkg::ST_BS_RD;
                end else if (q_gt) begin
                    n_state = stlp_pkg::ST_BS_RD;
                end else begin
                    n_state = stlp_pkg::ST_FETCH;
                end
            end
            stlp_pkg::ST_NR_LO: n_state = stlp_pkg::ST_NR_HI;
            stlp_pkg::ST_NR_HI: n_state = stlp_pkg::ST_FETCH;
            stlp_pkg::ST_FETCH: n_state = stlp_pkg::ST_CALC;
            stlp_pkg::ST_CALC: begin
                n_state = (den_s == '0) ? stlp_pkg::ST_DONE : stlp_pkg::ST_DIV;
            end
            stlp_pkg::ST_DIV: begin
                if (r_step == '0) begin
                    n_state = stlp_pkg::ST_DONE;
                end
            end
            stlp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = stlp_pkg::ST_IDLE;
                end
            end
            default: n_state = stlp_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath controls and read address
    // ---------------------------------------------------------------
    always_comb begin
        n_q    = r_q;
        n_st   = r_st;
        n_n    = r_n;
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_mid  = r_mid;
        n_idx  = r_idx;
        n_slo  = r_slo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_step = r_step;
        n_cerr = r_cerr;
        rd_addr = '0;
        case (r_state)
            stlp_pkg::ST_IDLE: begin
                // read entry 0 for the lower clamp
                n_q  = i_in.query_speed;
                n_st = i_in.query_stall;
                n_n  = cnt_clamped;
            end
            stlp_pkg::ST_CHK_FIRST: begin
                n_idx   = '0;
                rd_addr = n_minus1[IW-1:0];
            end
            stlp_pkg::ST_CHK_LAST: begin
                n_idx = n_minus1;
                n_lo  = '0;
                n_hi  = n_minus1;
            end
            stlp_pkg::ST_BS_RD: begin
                if (lo_le_hi) begin
                    n_mid   = mid_sum[CW:1];
                    rd_addr = mid_sum[IW:1];
                end else begin
                    n_idx   = r_hi;      // taken only by the lo-past-end guard
                    rd_addr = r_lo[IW-1:0];
                end
            end
            stlp_pkg::ST_BS_CMP: begin
                if (q_lt) begin
                    n_idx = '0;
                    n_hi  = r_mid - CW'(1);
                end else if (q_gt) begin
                    n_lo  = r_mid + CW'(1);
                end else begin
                    n_idx = r_mid;
                end
            end
            stlp_pkg::ST_NR_LO: begin
                n_slo   = r_rd.speed;
                rd_addr = r_hi[IW-1:0];
            end
            stlp_pkg::ST_NR_HI: begin
                n_idx = (dlo < dhi) ? r_lo : r_hi;
            end
            stlp_pkg::ST_FETCH: begin
                rd_addr = r_idx[IW-1:0];
            end
            stlp_pkg::ST_CALC: begin
                n_rem  = dividend;
                n_den  = den_mag;
                n_quo  = '0;
                n_step = 3'(stlp_pkg::QUO_MSB);
                n_cerr = (den_s == '0);
            end
            stlp_pkg::ST_DIV: begin
                if (div_take) begin
                    n_rem         = r_rem - div_shift;
                    n_quo[r_step] = 1'b1;
                end
                n_step = r_step - 3'd1;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequential logic
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stlp_pkg::ST_IDLE;
            r_eiu       <= stlp_pkg::CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_eiu <= i_cfg_wdata;
            end
            if (r_state == stlp_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_beat && slot_ok) begin
            r_mem[wr_addr] <= '{speed:    i_in.entry_speed,
                                noload:   i_in.entry_noload_stall,
                                fullload: i_in.entry_fullload_stall};
        end
        r_rd <= r_mem[rd_addr];
    end

    logic [CW+stlp_pkg::SLOT_W-1:0] idx_wide;
    assign idx_wide = {{stlp_pkg::SLOT_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_st   <= n_st;
        r_n    <= n_n;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_idx  <= n_idx;
        r_slo  <= n_slo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_step <= n_step;
        r_cerr <= n_cerr;
        if (r_state == stlp_pkg::ST_DONE && out_free) begin
            r_out_pct  <= r_cerr ? '0 : r_quo;
            r_out_near <= idx_wide[stlp_pkg::SLOT_W-1:0];
            r_out_err  <= r_cerr;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.load_percent      = r_out_pct;
    assign o_out.nearest_entry     = r_out_near;
    assign o_out.calibration_error = r_out_err;

endmodule

`default_nettype wire

/* sim/tb_stall_to_load_percent.sv */
`timescale 1ns / 1ps
// tb_stall_to_load_percent: self-checking bench for the stall-to-load lookup.
// Needs stlp_pkg, stlp_in_if, stlp_out_if and stall_to_load_percent from sv/.

module tb_stall_to_load_percent;

    localparam int DEPTH         = stlp_pkg::DEFAULT_TABLE_DEPTH;
    localparam int VAL_W         = stlp_pkg::VAL_W;
    localparam int SLOT_W        = stlp_pkg::SLOT_W;
    localparam int CNT_W         = stlp_pkg::CNT_W;
    localparam int PCT_W         = stlp_pkg::PCT_W;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;     // long sink stall, fills the block
    localparam int CYCLE_LIMIT   = 400000;
    localparam int VAL_MAX       = (1 << VAL_W) - 1;
    localparam int CNT_MAX       = (1 << CNT_W) - 1;
    localparam logic [VAL_W-1:0] VAL_ONES = '1;

    // One result beat as the block should produce it
    typedef struct packed {
        logic [PCT_W-1:0]  load_percent;
        logic [SLOT_W-1:0] nearest_entry;
        logic              cal_error;
    } t_load_result;

    // One input beat; only the fields the command uses matter
    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot;
        stlp_pkg::t_entry  entry;
        logic [VAL_W-1:0]  q_speed;
        logic [VAL_W-1:0]  q_stall;
    } t_cmd_beat;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    stlp_in_if  u_in_ch ();
    stlp_out_if u_out_ch ();

    stall_to_load_percent u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (u_in_ch),
        .o_out       (u_out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow of the block: calibration table and the entries_in_use
    // register. Updated at the edge where each beat is taken.
    stlp_pkg::t_entry cal_table [DEPTH];
    logic [CNT_W-1:0] entries_cfg;
    t_load_result     pending_loads [$];   // predicted results, oldest first
    t_load_result     oldest;

    int cycle_count     = 0;
    int mismatches      = 0;
    int beats_sent      = 0;
    int writes_sent     = 0;
    int queries_sent    = 0;
    int results_checked = 0;
    int error_flags     = 0;
    int config_writes   = 0;
    int sink_wait       = 0;   // cycles the sink still holds off after a beat
    bit no_gaps         = 1'b0;
    bit hold_start      = 1'b0;
    bit out_hold;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [VAL_W-1:0] rand_val();
        return VAL_W'($urandom_range(0, VAL_MAX));
    endfunction

    // A count of 0 searches one entry; anything past the depth searches all.
    function automatic int active_entries();
        if (entries_cfg == 0) return 1;
        if (entries_cfg > DEPTH) return DEPTH;
        return int'(entries_cfg);
    endfunction

    // Binary search for the nearest period. Clamps at both ends, lower slot
    // on a tie. Unsorted tables just get whatever this walk lands on.
    function automatic int find_nearest_slot(input int q, input int n);
        int lo, hi, mid, d_lo, d_hi;
        lo = 0;
        hi = n - 1;
        if (q < int'(cal_table[0].speed)) return 0;
        if (q > int'(cal_table[n - 1].speed)) return n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (q < int'(cal_table[mid].speed)) begin
                if (mid == 0) return 0;
                hi = mid - 1;
            end else if (q > int'(cal_table[mid].speed)) begin
                lo = mid + 1;
            end else begin
                return mid;
            end
        end
        if (lo >= n) return hi;
        d_lo = int'(cal_table[lo].speed) - q;
        d_hi = q - int'(cal_table[hi].speed);
        return (d_lo < d_hi) ? lo : hi;
    endfunction

    function automatic t_load_result predict_load(input logic [VAL_W-1:0] q_speed,
                                                  input logic [VAL_W-1:0] q_stall);
        t_load_result r;
        int slot, nl, fl, clamped, pct;
        slot    = find_nearest_slot(int'(q_speed), active_entries());
        nl      = int'(cal_table[slot].noload);
        fl      = int'(cal_table[slot].fullload);
        clamped = int'(q_stall);
        if (nl < clamped) clamped = nl;
        else if (fl > clamped) clamped = fl;
        if (nl == fl) begin
            // flat entry: no span to scale by
            pct         = 0;
            r.cal_error = 1'b1;
        end else begin
            // signed and truncating; inverted entries come out as 0 or 100
            pct         = ((nl - clamped) * 100) / (nl - fl);
            r.cal_error = 1'b0;
        end
        r.load_percent  = pct[PCT_W-1:0];
        r.nearest_entry = slot[SLOT_W-1:0];
        return r;
    endfunction

    // Load pair for one entry: mostly no-load above full-load, now and then
    // flat, inverted or full scale.
    function automatic void random_load_pair(output logic [VAL_W-1:0] noload,
                                             output logic [VAL_W-1:0] fullload);
        logic [VAL_W-1:0] a, b;
        a = rand_val();
        b = rand_val();
        case ($urandom_range(0, 9))
            0: begin
                noload   = a;
                fullload = a;
            end
            1: begin
                noload   = (a < b) ? a : b;
                fullload = (a < b) ? b : a;
            end
            2: begin
                noload   = VAL_ONES;
                fullload = '0;
            end
            default: begin
                noload   = (a > b) ? a : b;
                fullload = (a > b) ? b : a;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one beat after a random gap, hold it until taken, then update
    // the shadow state at that same edge.
    task automatic send_beat(input t_cmd_beat beat);
        int gap;
        t_load_result want;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            u_in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        u_in_ch.valid                <= 1'b1;
        u_in_ch.command              <= beat.command;
        u_in_ch.entry_index          <= beat.slot;
        u_in_ch.entry_speed          <= beat.entry.speed;
        u_in_ch.entry_noload_stall   <= beat.entry.noload;
        u_in_ch.entry_fullload_stall <= beat.entry.fullload;
        u_in_ch.query_speed          <= beat.q_speed;
        u_in_ch.query_stall          <= beat.q_stall;
        do begin
            @(posedge i_clk);
        end while (!(u_in_ch.valid && u_in_ch.ready));
        beats_sent++;
        if (beat.command == stlp_pkg::CMD_WRITE) begin
            cal_table[beat.slot] = beat.entry;
            writes_sent++;
        end else begin
            want = predict_load(beat.q_speed, beat.q_stall);
            if (want.cal_error) error_flags++;
            pending_loads.push_back(want);
            queries_sent++;
        end
    endtask

    // Write beat; the query fields carry noise
    task automatic write_entry(input logic [SLOT_W-1:0] slot, input logic [VAL_W-1:0] speed,
                               input logic [VAL_W-1:0] noload,
                               input logic [VAL_W-1:0] fullload);
        t_cmd_beat beat;
        beat.command        = stlp_pkg::CMD_WRITE;
        beat.slot           = slot;
        beat.entry.speed    = speed;
        beat.entry.noload   = noload;
        beat.entry.fullload = fullload;
        beat.q_speed        = rand_val();
        beat.q_stall        = rand_val();
        send_beat(beat);
    endtask

    // Query beat; the entry fields carry noise
    task automatic query_load(input logic [VAL_W-1:0] speed, input logic [VAL_W-1:0] stall);
        t_cmd_beat beat;
        beat.command        = stlp_pkg::CMD_QUERY;
        beat.slot           = SLOT_W'($urandom_range(0, DEPTH - 1));
        beat.entry.speed    = rand_val();
        beat.entry.noload   = rand_val();
        beat.entry.fullload = rand_val();
        beat.q_speed        = speed;
        beat.q_stall        = stall;
        send_beat(beat);
    endtask

    // Drop valid, let every predicted result arrive, then allow for a
    // write beat or a stray query still in the sequencer.
    task automatic wait_for_idle();
        @(negedge i_clk);
        u_in_ch.valid <= 1'b0;
        while (pending_loads.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_entries_in_use(input int value);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CNT_W-1:0];
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        entries_cfg = value[CNT_W-1:0];
        config_writes++;
    endtask

    // Sink: a random pause after every beat, plus the one long hold-off
    initial begin
        u_out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold) begin
                u_out_ch.ready <= 1'b0;
            end else if (sink_wait > 0) begin
                u_out_ch.ready <= 1'b0;
                sink_wait--;
            end else begin
                u_out_ch.ready <= 1'b1;
            end
        end
    end

    // Long stall, counted here so the sender keeps pushing meanwhile
    initial begin
        out_hold = 1'b0;
        wait (hold_start);
        @(posedge i_clk);
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold = 1'b0;
    end

    // Every result beat against the oldest prediction, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && u_out_ch.valid && u_out_ch.ready) begin
            results_checked++;
            if (pending_loads.size() == 0) begin
                report_mismatch("result beat with none outstanding",
                                int'(u_out_ch.load_percent), -1);
            end else begin
                oldest = pending_loads.pop_front();
                if (u_out_ch.load_percent !== oldest.load_percent)
                    report_mismatch("load_percent", int'(u_out_ch.load_percent),
                                    int'(oldest.load_percent));
                if (u_out_ch.nearest_entry !== oldest.nearest_entry)
                    report_mismatch("nearest_entry", int'(u_out_ch.nearest_entry),
                                    int'(oldest.nearest_entry));
                if (u_out_ch.calibration_error !== oldest.cal_error)
                    report_mismatch("calibration_error",
                                    int'(u_out_ch.calibration_error),
                                    int'(oldest.cal_error));
            end
            sink_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_loads.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked entries: clamps at both ends of the search, ties, exact
    // hits, a flat entry, an inverted entry, stall clamping and truncation.
    task automatic test_directed_lookup();
        no_gaps = 1'b0;
        // count is 1 out of reset, so slot 0 alone is searched
        write_entry(SLOT_W'(0), 16'd1000, VAL_ONES, 16'd0);
        query_load(16'd0, 16'd0);            // below first entry, stall at full load
        query_load(VAL_ONES, VAL_ONES);      // above last entry, stall at no load
        query_load(16'd1000, 16'd40000);
        set_entries_in_use(0);               // zero count behaves as one
        query_load(16'd500, 16'd32768);
        write_entry(SLOT_W'(1), 16'd2000, 16'd3000, 16'd1000);
        write_entry(SLOT_W'(2), 16'd3000, 16'd5000, 16'd5000);   // flat: error flag
        write_entry(SLOT_W'(3), 16'd4000, 16'd100, 16'd900);     // inverted loads
        set_entries_in_use(4);
        query_load(16'd1499, 16'd1234);
        query_load(16'd1500, 16'd1234);      // tie between slots 0 and 1
        query_load(16'd2500, 16'd2500);      // tie between slots 1 and 2
        query_load(16'd2501, 16'd2500);
        query_load(16'd3000, 16'd4000);      // exact hit on the flat entry
        query_load(16'd3600, 16'd50);        // inverted, clamps up to full load
        query_load(16'd3600, 16'd950);       // inverted, clamps down to no load
        query_load(16'd2000, 16'd2000);      // half way
        query_load(16'd2000, 16'd2999);      // truncates to 0
        query_load(16'd2000, 16'd1001);      // truncates to 99
    endtask

    // Sink holds off for a long stretch while queries keep coming, so the
    // output register and then the sequencer fill and input ready drops.
    task automatic test_output_stall();
        no_gaps    = 1'b1;
        hold_start = 1'b1;
        repeat (8) query_load(rand_val(), rand_val());
    endtask

    // Rounds of: pick a count, load the entries it makes active (mostly sorted, some
    // clustered), then aim queries at the entries, their midpoints and ends.
    task automatic test_random_tables();
        int start_beats, cfg_value, n, span, base, pick, nq, v;
        int speeds [$];
        logic [VAL_W-1:0] nl, fl, lo_v, hi_v, qst;
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       cfg_value = 0;
                1:       cfg_value = 1;
                2:       cfg_value = DEPTH;
                3:       cfg_value = CNT_MAX;
                4:       cfg_value = $urandom_range(DEPTH + 1, CNT_MAX - 1);
                default: cfg_value = $urandom_range(2, DEPTH);
            endcase
            set_entries_in_use(cfg_value);
            n = active_entries();

            // clustered periods give near ties and tiny gaps
            span = ($urandom_range(0, 2) == 0) ? 64 : VAL_MAX;
            base = $urandom_range(0, VAL_MAX - span);
            speeds.delete();
            for (int i = 0; i < n; i++) speeds.push_back(base + int'($urandom_range(0, span)));
            if ($urandom_range(0, 7) != 0) speeds.sort();
            for (int i = 0; i < n; i++) begin
                random_load_pair(nl, fl);
                write_entry(SLOT_W'(i), VAL_W'(speeds[i]), nl, fl);
            end
            // a slot outside the searched range now and then
            if (n < DEPTH && $urandom_range(0, 1) == 1) begin
                random_load_pair(nl, fl);
                write_entry(SLOT_W'($urandom_range(n, DEPTH - 1)), rand_val(), nl, fl);
            end

            nq = $urandom_range(8, 20);
            for (int j = 0; j < nq; j++) begin
                pick = $urandom_range(0, n - 1);
                if ($urandom_range(0, 15) == 0) begin
                    // recalibrate one entry between queries
                    random_load_pair(nl, fl);
                    write_entry(SLOT_W'(pick), VAL_W'(speeds[pick]), nl, fl);
                end else begin
                    case ($urandom_range(0, 5))
                        0: v = speeds[pick];
                        1: v = speeds[pick] + int'($urandom_range(0, 6)) - 3;
                        2: v = (pick < n - 1) ?
                               (speeds[pick] + speeds[pick + 1]) / 2 + int'($urandom_range(0, 1)) :
                               speeds[pick];
                        3: v = ($urandom_range(0, 1) == 1) ? VAL_MAX : 0;
                        default: v = $urandom_range(0, VAL_MAX);
                    endcase
                    if (v < 0) v = 0;
                    if (v > VAL_MAX) v = VAL_MAX;
                    nl   = cal_table[pick].noload;
                    fl   = cal_table[pick].fullload;
                    lo_v = (nl < fl) ? nl : fl;
                    hi_v = (nl < fl) ? fl : nl;
                    case ($urandom_range(0, 4))
                        0:       qst = nl;
                        1:       qst = fl;
                        2:       qst = VAL_W'($urandom_range(lo_v, hi_v));
                        3:       qst = ($urandom_range(0, 1) == 1) ? VAL_ONES : '0;
                        default: qst = rand_val();
                    endcase
                    query_load(v[VAL_W-1:0], qst);
                end
            end
        end
    endtask

    initial begin
        i_rst_n                      = 1'b0;
        cfg_we                       = 1'b0;
        cfg_wdata                    = '0;
        u_in_ch.valid                = 1'b0;
        u_in_ch.command              = stlp_pkg::CMD_WRITE;
        u_in_ch.entry_index          = '0;
        u_in_ch.entry_speed          = '0;
        u_in_ch.entry_noload_stall   = '0;
        u_in_ch.entry_fullload_stall = '0;
        u_in_ch.query_speed          = '0;
        u_in_ch.query_stall          = '0;
        entries_cfg                  = CNT_W'(1);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lookup();
        test_output_stall();
        test_random_tables();
        wait_for_idle();

        $display("Ran %0d table writes and %0d queries over %0d entries_in_use settings.",
                 writes_sent, queries_sent, config_writes);
        $display("Checked %0d results (%0d flagged flat entries), %0d mismatches.",
                 results_checked, error_flags, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/stlp_pkg.sv
sv/stlp_in_if.sv
sv/stlp_out_if.sv
sv/stall_to_load_percent.sv
sim/tb_stall_to_load_percent.sv
